>>> hdl/idct_pkg.sv
`timescale 1ns / 1ps
package idct_pkg;

  // Block geometry
  localparam int EDGE     = 8;
  localparam int EDGE_LOG = 3;
  localparam int NPIX     = EDGE * EDGE;
  localparam int ADDR_W   = 2 * EDGE_LOG;

  // Field and store widths
  localparam int COEF_W  = 21;
  localparam int ROW_W   = 32;
  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int SUM_W   = ROW_W + 2;

  localparam int FRAC_BITS_DEF = 13;

  // Butterfly constants, Q30
  localparam longint Q30_ROT_K     = 64'sd581104888;
  localparam longint Q30_ROT_A     = 64'sd1984016189;
  localparam longint Q30_ROT_B     = 64'sd821806414;
  localparam longint Q30_ODD_SCALE = 64'sd1262586814;
  localparam longint Q30_X7        = 64'sd320652955;
  localparam longint Q30_X5        = 64'sd2204520673;
  localparam longint Q30_X3        = 64'sd3299298342;
  localparam longint Q30_X1        = 64'sd1612031267;
  localparam longint Q30_P71       = 64'sd966342111;
  localparam longint Q30_P53       = 64'sd2751909507;
  localparam longint Q30_P73       = 64'sd2106220351;
  localparam longint Q30_P51       = 64'sd418953276;

  // Round a Q30 constant to the working fraction width
  function automatic longint fixc(input longint q30, input int frac);
    return (q30 + (longint'(1) <<< (29 - frac))) >>> (30 - frac);
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_BFLY,
    ST_WRITE,
    ST_EMIT
  } back_state_t;

  // Control from the transform engine back to the loader
  typedef struct packed {
    logic pop;
    logic lock;
  } blk_ctl_t;

endpackage

>>> hdl/idct_ram.sv
`timescale 1ns / 1ps
module idct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/idct_front.sv
`timescale 1ns / 1ps
module idct_front import idct_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [COEF_W-1:0] coefficient,
  input  blk_ctl_t                 ctl,
  output logic                     busy,
  output logic                     pending,
  output logic                     we,
  output logic [ADDR_W-1:0]        waddr,
  output logic [COEF_W-1:0]        wdata
);

  logic [ADDR_W-1:0] load_count;
  logic              accept;

  // Stall while a full block waits or the engine still reads the store
  assign busy   = pending | ctl.lock;
  assign accept = start & ~busy;

  assign we    = accept;
  assign waddr = load_count;
  assign wdata = coefficient;

  // Count loads; queue one block request when the store is full
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      pending    <= 1'b0;
    end else begin
      if (accept) begin
        if (load_count == ADDR_W'(NPIX - 1)) begin
          load_count <= '0;
          pending    <= 1'b1;
        end else begin
          load_count <= load_count + 1'b1;
        end
      end
      if (ctl.pop) begin
        pending <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/idct_bfly.sv
`timescale 1ns / 1ps
module idct_bfly import idct_pkg::*; #(
  parameter  int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CW        = FRAC_BITS + 3,
  localparam int ACC_W     = SUM_W + CW + 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [ROW_W-1:0] x [EDGE],
  output logic                    done,
  output logic signed [ACC_W-1:0] y [EDGE]
);

  localparam logic signed [CW-1:0] K_ROT = CW'(fixc(Q30_ROT_K, FRAC_BITS));
  localparam logic signed [CW-1:0] K_A   = CW'(fixc(Q30_ROT_A, FRAC_BITS));
  localparam logic signed [CW-1:0] K_B   = CW'(fixc(Q30_ROT_B, FRAC_BITS));
  localparam logic signed [CW-1:0] K_SC  = CW'(fixc(Q30_ODD_SCALE, FRAC_BITS));
  localparam logic signed [CW-1:0] K_X7  = CW'(fixc(Q30_X7, FRAC_BITS));
  localparam logic signed [CW-1:0] K_X5  = CW'(fixc(Q30_X5, FRAC_BITS));
  localparam logic signed [CW-1:0] K_X3  = CW'(fixc(Q30_X3, FRAC_BITS));
  localparam logic signed [CW-1:0] K_X1  = CW'(fixc(Q30_X1, FRAC_BITS));
  localparam logic signed [CW-1:0] K_P71 = CW'(fixc(Q30_P71, FRAC_BITS));
  localparam logic signed [CW-1:0] K_P53 = CW'(fixc(Q30_P53, FRAC_BITS));
  localparam logic signed [CW-1:0] K_P73 = CW'(fixc(Q30_P73, FRAC_BITS));
  localparam logic signed [CW-1:0] K_P51 = CW'(fixc(Q30_P51, FRAC_BITS));
  localparam int LAT = 5;

  logic [LAT-1:0] vld;

  // Stage 1 registers
  logic signed [SUM_W-1:0] a26, a04p, a04m, p73, p51, p71, p53, pall;
  logic signed [SUM_W-1:0] d1, d2, d3, d5, d6, d7;
  // Stage 2 registers
  logic signed [ACC_W-1:0] rot, m6, m2, e0_2, e1_2, sc, m71, m53, r73_2, r51_2;
  logic signed [ACC_W-1:0] mx7_2, mx5_2, mx3_2, mx1_2;
  // Stage 3 registers
  logic signed [ACC_W-1:0] e0_3, e1_3, e2, e3, q71, q53, r73_3, r51_3;
  logic signed [ACC_W-1:0] mx7_3, mx5_3, mx3_3, mx1_3;
  // Stage 4 registers
  logic signed [ACC_W-1:0] s0, s1, s2, s3, o0, o1, o2, o3;

  // Track the request through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], go};
    end
  end

  assign done = vld[LAT-1];

  always_ff @(posedge clk) begin
    // Form input sums
    a26  <= SUM_W'(x[2]) + SUM_W'(x[6]);
    a04p <= SUM_W'(x[0]) + SUM_W'(x[4]);
    a04m <= SUM_W'(x[0]) - SUM_W'(x[4]);
    p73  <= SUM_W'(x[7]) + SUM_W'(x[3]);
    p51  <= SUM_W'(x[5]) + SUM_W'(x[1]);
    p71  <= SUM_W'(x[7]) + SUM_W'(x[1]);
    p53  <= SUM_W'(x[5]) + SUM_W'(x[3]);
    pall <= SUM_W'(x[7]) + SUM_W'(x[3]) + SUM_W'(x[5]) + SUM_W'(x[1]);
    d1   <= SUM_W'(x[1]);
    d2   <= SUM_W'(x[2]);
    d3   <= SUM_W'(x[3]);
    d5   <= SUM_W'(x[5]);
    d6   <= SUM_W'(x[6]);
    d7   <= SUM_W'(x[7]);

    // Multiply by the butterfly constants; shift the even sums up to the fraction width
    rot   <= ACC_W'(a26) * ACC_W'(K_ROT);
    m6    <= ACC_W'(d6) * ACC_W'(K_A);
    m2    <= ACC_W'(d2) * ACC_W'(K_B);
    e0_2  <= ACC_W'(a04p) <<< FRAC_BITS;
    e1_2  <= ACC_W'(a04m) <<< FRAC_BITS;
    sc    <= ACC_W'(pall) * ACC_W'(K_SC);
    m71   <= ACC_W'(p71) * ACC_W'(K_P71);
    m53   <= ACC_W'(p53) * ACC_W'(K_P53);
    r73_2 <= ACC_W'(p73) * ACC_W'(K_P73);
    r51_2 <= ACC_W'(p51) * ACC_W'(K_P51);
    mx7_2 <= ACC_W'(d7) * ACC_W'(K_X7);
    mx5_2 <= ACC_W'(d5) * ACC_W'(K_X5);
    mx3_2 <= ACC_W'(d3) * ACC_W'(K_X3);
    mx1_2 <= ACC_W'(d1) * ACC_W'(K_X1);

    // Combine rotation and odd-scale terms
    e0_3  <= e0_2;
    e1_3  <= e1_2;
    e2    <= rot - m6;
    e3    <= rot + m2;
    q71   <= sc - m71;
    q53   <= sc - m53;
    r73_3 <= r73_2;
    r51_3 <= r51_2;
    mx7_3 <= mx7_2;
    mx5_3 <= mx5_2;
    mx3_3 <= mx3_2;
    mx1_3 <= mx1_2;

    // Even and odd halves
    s0 <= e0_3 + e3;
    s3 <= e0_3 - e3;
    s1 <= e1_3 + e2;
    s2 <= e1_3 - e2;
    o0 <= mx7_3 + q71 - r73_3;
    o1 <= mx5_3 + q53 - r51_3;
    o2 <= mx3_3 + q53 - r73_3;
    o3 <= mx1_3 + q71 - r51_3;

    // Final butterfly
    y[0] <= s0 + o3;
    y[1] <= s1 + o2;
    y[2] <= s2 + o1;
    y[3] <= s3 + o0;
    y[4] <= s3 - o0;
    y[5] <= s2 - o1;
    y[6] <= s1 - o2;
    y[7] <= s0 - o3;
  end

endmodule

>>> hdl/idct_back.sv
`timescale 1ns / 1ps
module idct_back import idct_pkg::*; #(
  parameter  int FRAC_BITS = FRAC_BITS_DEF,
  localparam int ACC_W     = SUM_W + FRAC_BITS + 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pending,
  output blk_ctl_t          ctl,
  output logic [ADDR_W-1:0] coef_raddr,
  input  logic [COEF_W-1:0] coef_rdata,
  output logic              strobe,
  output logic [PIX_W-1:0]  pixel,
  output logic [ADDR_W-1:0] pixel_index,
  output logic              last_pixel
);

  localparam int IDX_W = EDGE_LOG + 1;

  back_state_t state, state_next;

  logic [IDX_W-1:0]    idx;
  logic [EDGE_LOG-1:0] line;
  logic                col;
  logic [ADDR_W-1:0]   ecnt;
  logic                rd_vld;
  logic                go;
  logic                ac_nz;
  logic                done;

  logic signed [ROW_W-1:0] x [EDGE];
  logic signed [ROW_W-1:0] rd_data;
  logic signed [ACC_W-1:0] y [EDGE];
  logic signed [ACC_W-1:0] y_sel, rsum, rq, tsum, pq;

  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              row_we, pix_we;
  logic [ROW_W-1:0]  row_wdata, row_rdata;
  logic [PIX_W-1:0]  pix_wdata, pix_rdata;

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    ctl.pop    = 1'b0;
    ctl.lock   = (state != ST_IDLE) && (state != ST_EMIT) && !col;
    unique case (state)
      ST_IDLE: begin
        if (pending) begin
          ctl.pop    = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (idx == IDX_W'(EDGE)) begin
          state_next = ST_BFLY;
        end
      end
      ST_BFLY: begin
        if (done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (idx == IDX_W'(EDGE - 1)) begin
          if (line == EDGE_LOG'(EDGE - 1) && col) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_EMIT: begin
        if (ecnt == ADDR_W'(NPIX - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance line, element and emit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      line   <= '0;
      col    <= 1'b0;
      ecnt   <= '0;
      rd_vld <= 1'b0;
      go     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      rd_vld <= (state == ST_READ) && (idx != IDX_W'(EDGE));
      go     <= (state == ST_READ) && (idx == IDX_W'(EDGE));
      strobe <= (state == ST_EMIT);
      case (state)
        ST_IDLE: begin
          idx  <= '0;
          line <= '0;
          col  <= 1'b0;
          ecnt <= '0;
        end
        ST_READ: begin
          idx <= (idx == IDX_W'(EDGE)) ? '0 : idx + 1'b1;
        end
        ST_WRITE: begin
          if (idx == IDX_W'(EDGE - 1)) begin
            idx  <= '0;
            line <= line + 1'b1;
            if (line == EDGE_LOG'(EDGE - 1)) begin
              col <= 1'b1;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_EMIT: begin
          ecnt <= ecnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Rows read from the coefficient store, columns from the row-pass store
  assign rd_addr    = col ? {idx[EDGE_LOG-1:0], line} : {line, idx[EDGE_LOG-1:0]};
  assign wr_addr    = rd_addr;
  assign coef_raddr = rd_addr;
  assign rd_data    = col ? $signed(row_rdata) : ROW_W'($signed(coef_rdata));

  // Shift the line in; note any nonzero AC term of a row
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      for (int i = 0; i < EDGE - 1; i++) begin
        x[i] <= x[i + 1];
      end
      x[EDGE - 1] <= rd_data;
    end
    if (state == ST_READ && idx == '0) begin
      ac_nz <= 1'b0;
    end else if (rd_vld && idx != IDX_W'(1) && rd_data != '0) begin
      ac_nz <= 1'b1;
    end
  end

  idct_bfly #(
    .FRAC_BITS(FRAC_BITS)
  ) u_bfly (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .x   (x),
    .done(done),
    .y   (y)
  );

  // Round row results to Q2; level-shift and clamp column results
  always_comb begin
    y_sel = y[idx[EDGE_LOG-1:0]];
    rsum  = y_sel + (ACC_W'(1) <<< (FRAC_BITS - 3));
    rq    = rsum >>> (FRAC_BITS - 2);
    tsum  = y_sel + (ACC_W'(1028) <<< (FRAC_BITS + 2));
    pq    = tsum >>> (FRAC_BITS + 5);
    row_wdata = ac_nz ? rq[ROW_W-1:0] : (x[0] <<< 2);
    if (tsum[ACC_W-1]) begin
      pix_wdata = '0;
    end else if (pq > ACC_W'(PIX_MAX)) begin
      pix_wdata = PIX_W'(PIX_MAX);
    end else begin
      pix_wdata = pq[PIX_W-1:0];
    end
  end

  assign row_we = (state == ST_WRITE) && !col;
  assign pix_we = (state == ST_WRITE) && col;

  idct_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NPIX)
  ) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(wr_addr),
    .wdata(row_wdata),
    .raddr(rd_addr),
    .rdata(row_rdata)
  );

  idct_ram #(
    .WIDTH(PIX_W),
    .DEPTH(NPIX)
  ) u_pix_ram (
    .clk  (clk),
    .we   (pix_we),
    .waddr(wr_addr),
    .wdata(pix_wdata),
    .raddr(ecnt),
    .rdata(pix_rdata)
  );

  // Emit pixels in row-major order, aligned with the registered read
  always_ff @(posedge clk) begin
    pixel_index <= ecnt;
  end

  assign pixel      = pix_rdata;
  assign last_pixel = (pixel_index == ADDR_W'(NPIX - 1));

endmodule

>>> hdl/idct_8x8_llm.sv
`timescale 1ns / 1ps
// From the 64th coefficient to the last pixel: an idle state, 16 line passes (read the
//   line, run the shared butterfly, write the results), then 64 pixels on consecutive
//   cycles behind the registered pixel-store read.
// Throughput: one coefficient per cycle while loading, when busy is low; the block rate is
//   set by the single shared butterfly and the one read port per store.
// Loading of the next block resumes once the row pass ends. Reset clears all control
//   state; the stores hold no reset value. Pixels cannot be stalled by the receiver.
module idct_8x8_llm import idct_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [COEF_W-1:0] coefficient,
  output logic                     busy,
  output logic                     strobe,
  output logic [PIX_W-1:0]         pixel,
  output logic [ADDR_W-1:0]        pixel_index,
  output logic                     last_pixel
);

  blk_ctl_t          ctl;
  logic              pending;
  logic              coef_we;
  logic [ADDR_W-1:0] coef_waddr, coef_raddr;
  logic [COEF_W-1:0] coef_wdata, coef_rdata;

  idct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .coefficient(coefficient),
    .ctl        (ctl),
    .busy       (busy),
    .pending    (pending),
    .we         (coef_we),
    .waddr      (coef_waddr),
    .wdata      (coef_wdata)
  );

  idct_ram #(
    .WIDTH(COEF_W),
    .DEPTH(NPIX)
  ) u_coef_ram (
    .clk  (clk),
    .we   (coef_we),
    .waddr(coef_waddr),
    .wdata(coef_wdata),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  idct_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pending    (pending),
    .ctl        (ctl),
    .coef_raddr (coef_raddr),
    .coef_rdata (coef_rdata),
    .strobe     (strobe),
    .pixel      (pixel),
    .pixel_index(pixel_index),
    .last_pixel (last_pixel)
  );

endmodule

>>> test/idct_8x8_llm_test.sv
`timescale 1ns / 1ps
module idct_8x8_llm_test;
  import idct_pkg::*;

  typedef struct {
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] pixel_index;
    logic              last_pixel;
  } pixel_req_t;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 20000;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic signed [COEF_W-1:0] coefficient;
  logic                     busy;
  logic                     strobe;
  logic [PIX_W-1:0]         pixel;
  logic [ADDR_W-1:0]        pixel_index;
  logic                     last_pixel;

  idct_8x8_llm dut (
    .clk(clk), .rst(rst), .start(start), .coefficient(coefficient),
    .busy(busy), .strobe(strobe), .pixel(pixel), .pixel_index(pixel_index),
    .last_pixel(last_pixel)
  );

  logic signed [COEF_W-1:0] coef_queue[$];
  pixel_req_t               pixel_expect[$];
  longint                   coef_block[64];
  int                       load_pos;
  int                       errors;
  int                       coefs_sent;
  int                       pixels_seen;
  int                       idle_cycles;
  int                       gap;
  bit                       stim_done;
  bit                       accepted;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // 1-D butterfly, outputs scaled by 2^FRAC
  function automatic void butterfly_1d(input longint x[8], output longint y[8]);
    longint rot, e0, e1, e2, e3, s0, s1, s2, s3;
    longint p73, p51, p71, p53, sc, q71, q53, r73, r51, o0, o1, o2, o3;
    rot = (x[2] + x[6]) * fixc(Q30_ROT_K, FRAC);
    e2 = rot - x[6] * fixc(Q30_ROT_A, FRAC);
    e3 = rot + x[2] * fixc(Q30_ROT_B, FRAC);
    e0 = (x[0] + x[4]) <<< FRAC;
    e1 = (x[0] - x[4]) <<< FRAC;
    s0 = e0 + e3; s3 = e0 - e3; s1 = e1 + e2; s2 = e1 - e2;
    p73 = x[7] + x[3]; p51 = x[5] + x[1];
    p71 = x[7] + x[1]; p53 = x[5] + x[3];
    sc = (p73 + p51) * fixc(Q30_ODD_SCALE, FRAC);
    q71 = sc - p71 * fixc(Q30_P71, FRAC);
    q53 = sc - p53 * fixc(Q30_P53, FRAC);
    r73 = p73 * fixc(Q30_P73, FRAC);
    r51 = p51 * fixc(Q30_P51, FRAC);
    o0 = x[7] * fixc(Q30_X7, FRAC) + q71 - r73;
    o1 = x[5] * fixc(Q30_X5, FRAC) + q53 - r51;
    o2 = x[3] * fixc(Q30_X3, FRAC) + q53 - r73;
    o3 = x[1] * fixc(Q30_X1, FRAC) + q71 - r51;
    y[0] = s0 + o3; y[1] = s1 + o2; y[2] = s2 + o1; y[3] = s3 + o0;
    y[4] = s3 - o0; y[5] = s2 - o1; y[6] = s1 - o2; y[7] = s0 - o3;
  endfunction

  // Reconstruct one block and queue its 64 pixels in row-major order
  task automatic reconstruct_block();
    longint     a[8], b[8], rows[64], t;
    pixel_req_t px[64];
    bit         ac_zero;
    for (int r = 0; r < 8; r++) begin
      ac_zero = 1'b1;
      for (int c = 0; c < 8; c++) begin
        a[c] = coef_block[r*8+c];
        if (c != 0 && a[c] != 0) ac_zero = 1'b0;
      end
      if (ac_zero) begin
        for (int c = 0; c < 8; c++) rows[r*8+c] = a[0] * 4;
      end else begin
        butterfly_1d(a, b);
        for (int c = 0; c < 8; c++)
          rows[r*8+c] = (b[c] + (longint'(1) <<< (FRAC-3))) >>> (FRAC-2);
      end
    end
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) a[r] = rows[r*8+c];
      butterfly_1d(a, b);
      for (int r = 0; r < 8; r++) begin
        t = (b[r] + 1028 * (longint'(1) <<< (FRAC+2))) >>> (FRAC+5);
        if (t < 0) t = 0;
        if (t > PIX_MAX) t = PIX_MAX;
        px[r*8+c].pixel = t[PIX_W-1:0];
        px[r*8+c].pixel_index = ADDR_W'(r*8+c);
        px[r*8+c].last_pixel = (r*8+c == NPIX-1);
      end
    end
    for (int k = 0; k < NPIX; k++) pixel_expect.push_back(px[k]);
  endtask

  // Drive one request per draw, with a random gap before it
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else if (accepted) begin
      start <= 1'b0;
      gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    end else if (!start && coef_queue.size() > 0) begin
      if (gap > 0) gap <= gap - 1;
      else begin
        coefficient <= coef_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Predict on accepted requests, check pixels, watch for stalls
  always @(posedge clk) begin
    accepted <= !rst && start && !busy;
    if (!rst) begin
      if ((start && !busy) || strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        coefs_sent <= coefs_sent + 1;
        coef_block[load_pos] = coefficient;
        if (load_pos == NPIX-1) begin
          load_pos = 0;
          reconstruct_block();
        end else load_pos = load_pos + 1;
      end
      if (strobe) begin
        pixels_seen <= pixels_seen + 1;
        if (pixel_expect.size() == 0) begin
          $display("%0t: unexpected pixel %0d index %0d", $time, pixel, pixel_index);
          errors <= errors + 1;
        end else begin
          pixel_req_t e;
          e = pixel_expect.pop_front();
          if (e.pixel !== pixel || e.pixel_index !== pixel_index ||
              e.last_pixel !== last_pixel) begin
            $display("%0t: pixel mismatch expected %0d/%0d/%0b actual %0d/%0d/%0b",
                     $time, e.pixel, e.pixel_index, e.last_pixel,
                     pixel, pixel_index, last_pixel);
            errors <= errors + 1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("idct_8x8_llm_test NOT OK");
        $finish;
      end
    end
  end

  // Push coefficients, one pattern per row, rotating from a given style
  task automatic queue_block(input int style, input int count);
    logic signed [COEF_W-1:0] v;
    for (int k = 0; k < count; k++) begin
      case ((style + k / 8) % 6)
        0: v = (k % 8 == 0) ? COEF_W'($urandom_range(0, 2047)) - 21'sd1024 : 21'sd0;
        1: v = (k % 2) ? 21'sh0FFFFF : 21'sh100000;
        2: v = COEF_W'($urandom);
        3: v = ($urandom_range(0, 3) == 0) ?
               COEF_W'($urandom_range(0, 4095)) - 21'sd2048 : 21'sd0;
        4: v = ((k % 8) == 0) ? COEF_W'($urandom_range(0, 1023)) - 21'sd512 :
               (($urandom_range(0, 7) == 0) ? 21'sd1 : 21'sd0);
        default: v = COEF_W'($urandom_range(0, 255)) - 21'sd128;
      endcase
      coef_queue.push_back(v);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    coefficient = '0;
    load_pos = 0;
    errors = 0;
    coefs_sent = 0;
    pixels_seen = 0;
    idle_cycles = 0;
    gap = 0;
    stim_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // Two full blocks mixing DC-only, extreme, random and sparse rows, then a partial load
    queue_block(0, NPIX);
    queue_block(3, NPIX);
    queue_block(1, NPIX / 2);
    wait (coef_queue.size() == 0 && !start);
    wait (pixel_expect.size() == 0);
    repeat (500) @(posedge clk);
    $display("Covered %0d coefficients (%0d full blocks) and %0d pixels",
             coefs_sent, coefs_sent / NPIX, pixels_seen);
    if (errors == 0) begin
      $display("idct_8x8_llm_test OK");
    end else begin
      $display("idct_8x8_llm_test NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/idct_pkg.sv
hdl/idct_ram.sv
hdl/idct_front.sv
hdl/idct_bfly.sv
hdl/idct_back.sv
hdl/idct_8x8_llm.sv
test/idct_8x8_llm_test.sv
